[hw/rtl/assert_macros.svh]
// Assertion macros used by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define GWM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define GWM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/gwm_pkg.sv]
// Types, constants and helper functions of the glob wildcard matcher.
`timescale 1ns / 1ps

package gwm_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_NAME   = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  localparam logic [7:0] SYM_ANY  = 8'h3F;
  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_A    = 8'h41;
  localparam logic [7:0] SYM_Z    = 8'h5A;
  localparam logic [7:0] SYM_LA   = 8'h61;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       step;
    logic       at_home;
    logic       fold;
    logic [7:0] wr_byte;
    logic [7:0] name_byte;
  } cell_ctl_t;

  // Handed from one cell to the next in pattern order.
  typedef struct packed {
    logic adv;
    logic skip;
    logic wr;
    logic home;
  } cell_link_t;

  // Per-cell contribution to the match result.
  typedef struct packed {
    logic end_hit;
    logic home_hit;
  } cell_stat_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c inside {[SYM_A:SYM_Z]})) begin
      r = c - SYM_A + SYM_LA;
    end
    return r;
  endfunction

endpackage

[hw/rtl/gwm_cell.sv]
// One pattern position: stored pattern byte and its bit of the active set.
`timescale 1ns / 1ps

module gwm_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gwm_pkg::cell_ctl_t    ctl,
  input  logic [LEN_W-1:0]      len,
  input  gwm_pkg::cell_link_t   link_in,
  output gwm_pkg::cell_link_t   link_out,
  output gwm_pkg::cell_stat_t   stat
);

  localparam logic [LEN_W-1:0] MY_POS = LEN_W'(IDX);
  localparam logic             HOME_RESET = (IDX == 0);

  logic [7:0] pat_r, pat_nxt;
  logic       act_r, act_nxt;
  logic       home_r, home_nxt;

  logic in_use;
  logic is_end;
  logic wr_this;
  logic pat_star;
  logic byte_hit;
  logic cur;
  logic raw;
  logic nc;

  assign in_use   = (len > MY_POS);
  assign is_end   = (len == MY_POS);
  assign wr_this  = ctl.append && is_end;
  assign pat_star = (pat_r == gwm_pkg::SYM_STAR);
  assign byte_hit = (pat_r == gwm_pkg::SYM_ANY) ||
                    (gwm_pkg::fold_byte(pat_r, ctl.fold) == ctl.name_byte);

  // After a restart the set is the star closure of the start position,
  // which each cell keeps up to date in home_r as the pattern is loaded.
  assign cur = ctl.at_home ? home_r : act_r;

  // A star keeps its own position; any other byte moves on to the next one when it matches.
  assign raw = (cur && in_use && pat_star) || link_in.adv;
  assign nc  = raw || link_in.skip;

  assign link_out.adv  = cur && in_use && !pat_star && byte_hit;
  assign link_out.skip = nc && in_use && pat_star;
  assign link_out.wr   = wr_this;
  assign link_out.home = home_r && (ctl.wr_byte == gwm_pkg::SYM_STAR);

  assign stat.end_hit  = nc && is_end;
  assign stat.home_hit = home_r && is_end;

  always_comb begin
    pat_nxt  = wr_this ? ctl.wr_byte : pat_r;
    act_nxt  = ctl.step ? nc : act_r;
    home_nxt = home_r;
    if (ctl.clear) begin
      home_nxt = HOME_RESET;
    end else if (link_in.wr) begin
      home_nxt = link_in.home;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r <= HOME_RESET;
    end else begin
      home_r <= home_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    act_r <= act_nxt;
  end

endmodule

[hw/rtl/glob_wildcard_matcher.sv]
// Top level of the glob wildcard matcher: command decode, cell row and result buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Glob matcher for a pattern of up to PATTERN_MAX bytes, where '*' matches any
// run of bytes and '?' matches one byte. Send a clear, then the pattern bytes one
// transaction each, then name bytes with last set on the final one (or an
// empty-name query); one result follows each name. A new transaction may be
// taken in every cycle while the input is not stalled; each result is registered
// into a two-entry output buffer, from which it is presented.
// The input stalls only while both buffer entries hold results or reset is asserted.
// The clock period is set by the star-skip signal, which ripples combinationally
// through the whole row of PATTERN_MAX + 1 cells. Pattern bytes beyond PATTERN_MAX are
// dropped and reported with every result until the next clear.
module glob_wildcard_matcher #(
  parameter int PATTERN_MAX = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [7:0] in_symbol,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_pattern_overflow
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);

  gwm_pkg::func_t      func;
  logic                fire;
  logic                full;
  logic                drop;
  logic                push;
  logic                pop;
  logic                res_matched;
  logic                tail_busy;
  gwm_pkg::cell_ctl_t  ctl;
  gwm_pkg::cell_link_t link [PATTERN_MAX+2];
  logic [PATTERN_MAX:0] end_hit;
  logic [PATTERN_MAX:0] home_hit;

  logic             case_fold_r, case_fold_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             at_home_r, at_home_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r, out_matched_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic             skid_matched_r, skid_matched_nxt;
  logic             skid_ovf_r, skid_ovf_nxt;

  assign func     = gwm_pkg::func_t'(in_func);
  assign in_stall = skid_valid_r || !rst_n;
  assign fire     = in_valid && !in_stall;
  assign full     = (len_r == LEN_FULL);
  assign drop     = fire && full && (func == gwm_pkg::FUNC_APPEND);
  assign push     = fire && (((func == gwm_pkg::FUNC_NAME) && in_last) ||
                             (func == gwm_pkg::FUNC_QUERY));
  assign pop      = out_valid_r && !out_stall;

  assign ctl.clear     = fire && (func == gwm_pkg::FUNC_CLEAR);
  assign ctl.append    = fire && (func == gwm_pkg::FUNC_APPEND) && !full;
  assign ctl.step      = fire && (func == gwm_pkg::FUNC_NAME);
  assign ctl.at_home   = at_home_r;
  assign ctl.fold      = case_fold_r;
  assign ctl.wr_byte   = in_symbol;
  assign ctl.name_byte = gwm_pkg::fold_byte(in_symbol, case_fold_r);

  assign link[0] = '0;

  for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_cell
    gwm_pkg::cell_stat_t stat;
    gwm_cell #(.IDX(i), .LEN_W(LEN_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .len      (len_r),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .stat     (stat)
    );
    assign end_hit[i]  = stat.end_hit;
    assign home_hit[i] = stat.home_hit;
  end

  // The last cell sits past every stored byte, so it never hands anything on.
  assign tail_busy = link[PATTERN_MAX+1].adv || link[PATTERN_MAX+1].skip ||
                     link[PATTERN_MAX+1].wr;

  assign res_matched = (func == gwm_pkg::FUNC_QUERY) ? (|home_hit) : (|end_hit);

  always_comb begin
    case_fold_nxt = cfg_we ? cfg_wdata : case_fold_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    at_home_nxt   = at_home_r;
    if (fire) begin
      case (func)
        gwm_pkg::FUNC_CLEAR: begin
          len_nxt     = '0;
          ovf_nxt     = 1'b0;
          at_home_nxt = 1'b1;
        end
        gwm_pkg::FUNC_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt = len_r + 1'b1;
          end
          at_home_nxt = 1'b1;
        end
        gwm_pkg::FUNC_NAME: begin
          at_home_nxt = in_last;
        end
        default: begin
          at_home_nxt = 1'b1;
        end
      endcase
    end
  end

  // Two-entry result buffer: the skid entry fills only when the head is held.
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_matched_nxt  = out_matched_r;
    out_ovf_nxt      = out_ovf_r;
    skid_valid_nxt   = skid_valid_r;
    skid_matched_nxt = skid_matched_r;
    skid_ovf_nxt     = skid_ovf_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_matched_nxt = skid_matched_r;
        out_ovf_nxt     = skid_ovf_r;
        skid_valid_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt   = 1'b1;
        out_matched_nxt = res_matched;
        out_ovf_nxt     = ovf_r;
      end else begin
        skid_valid_nxt   = 1'b1;
        skid_matched_nxt = res_matched;
        skid_ovf_nxt     = ovf_r;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_fold_r  <= 1'b0;
      len_r        <= '0;
      ovf_r        <= 1'b0;
      at_home_r    <= 1'b1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      case_fold_r  <= case_fold_nxt;
      len_r        <= len_nxt;
      ovf_r        <= ovf_nxt;
      at_home_r    <= at_home_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r  <= out_matched_nxt;
    out_ovf_r      <= out_ovf_nxt;
    skid_matched_r <= skid_matched_nxt;
    skid_ovf_r     <= skid_ovf_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

  `GWM_ASSERT(a_skid_behind_head, clk, rst_n, skid_valid_r |-> out_valid_r, "orphan skid entry")
  `GWM_ASSERT(a_len_in_range, clk, rst_n, len_r <= LEN_FULL, "length past capacity")
  `GWM_ASSERT(a_ovf_source, clk, rst_n, $rose(ovf_r) |-> $past(drop), "overflow without a drop")
  `GWM_ASSERT(a_restart_after_result, clk, rst_n, push |=> at_home_r, "no restart")
  `GWM_ASSERT(a_tail_idle, clk, rst_n, !tail_busy, "tail cell hands on data")
  `GWM_ASSERT_ALWAYS(a_no_take_in_reset, clk, !rst_n |-> in_stall, "input taken in reset")

endmodule

[verif/glob_wildcard_matcher_tb.sv]
// Self-checking testbench for the glob wildcard matcher with random pacing on both channels.
`timescale 1ns / 1ps

module glob_wildcard_matcher_tb;

  localparam int PATTERN_MAX = 63;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_TARGET = 1350;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_func = gwm_pkg::FUNC_CLEAR;
  logic [7:0] in_symbol = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_matched;
  logic       out_pattern_overflow;

  // Shadow state of the matcher.
  logic [7:0]  glob_bytes [0:PATTERN_MAX-1];
  int          glob_len = 0;
  logic        glob_overflow = 1'b0;
  logic [63:0] live_positions = 64'd1;
  logic        fold_on = 1'b0;
  verdict_t    pending_verdicts [$];

  // Sender pacing and pressure control.
  int   items_sent = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  bit   holding_valid = 1'b0;
  int   hold_seq = 0;
  int   mismatches = 0;
  int   verdicts_seen = 0;
  int   idle_cycles = 0;

  // Receiver pattern state, written only by the receiver process.
  int   hold_seen = 0;
  int   hold_left = 0;
  int   seg_left = 0;
  int   seg_mode = 0;

  // Byte strings shared by the stimulus tasks.
  logic [7:0] glob_buf [$];
  logic [7:0] name_buf [$];

  glob_wildcard_matcher #(
    .PATTERN_MAX(PATTERN_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_symbol(in_symbol),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_matched(out_matched),
    .out_pattern_overflow(out_pattern_overflow)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] to_lower(input logic [7:0] c, input logic en);
    if (en && c >= gwm_pkg::SYM_A && c <= gwm_pkg::SYM_Z) begin
      return c - gwm_pkg::SYM_A + gwm_pkg::SYM_LA;
    end
    return c;
  endfunction

  // A star may match an empty run, so any live star position also makes the next one live.
  function automatic logic [63:0] close_stars(input logic [63:0] s);
    logic [63:0] r;
    r = s;
    for (int p = 0; p < glob_len; p++) begin
      if (r[p] && glob_bytes[p] == gwm_pkg::SYM_STAR) begin
        r[p+1] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] advance_positions(input logic [63:0] s, input logic [7:0] b);
    logic [63:0] c;
    logic [63:0] nxt;
    logic [7:0]  nb;
    c = close_stars(s);
    nxt = '0;
    nb = to_lower(b, fold_on);
    for (int p = 0; p < glob_len; p++) begin
      if (c[p]) begin
        if (glob_bytes[p] == gwm_pkg::SYM_STAR) begin
          nxt[p] = 1'b1;
        end else if (glob_bytes[p] == gwm_pkg::SYM_ANY ||
                     to_lower(glob_bytes[p], fold_on) == nb) begin
          nxt[p+1] = 1'b1;
        end
      end
    end
    return nxt;
  endfunction

  function automatic void push_verdict(input logic [63:0] s);
    logic [63:0] c;
    verdict_t v;
    c = close_stars(s);
    v.matched = c[glob_len];
    v.overflow = glob_overflow;
    pending_verdicts.insert(pending_verdicts.size(), v);
    live_positions = 64'd1;
  endfunction

  function automatic void update_matcher_state(input gwm_pkg::func_t f, input logic [7:0] sym,
                                               input logic is_last);
    case (f)
      gwm_pkg::FUNC_CLEAR: begin
        glob_len = 0;
        glob_overflow = 1'b0;
        live_positions = 64'd1;
      end
      gwm_pkg::FUNC_APPEND: begin
        if (glob_len < PATTERN_MAX) begin
          glob_bytes[glob_len] = sym;
          glob_len++;
        end else begin
          glob_overflow = 1'b1;
        end
        live_positions = 64'd1;
      end
      gwm_pkg::FUNC_NAME: begin
        live_positions = advance_positions(live_positions, sym);
        if (is_last) begin
          push_verdict(live_positions);
        end
      end
      default: begin
        push_verdict(64'd1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_item(input gwm_pkg::func_t f, input logic [7:0] sym, input logic is_last);
    in_valid <= 1'b1;
    in_func <= f;
    in_symbol <= sym;
    in_last <= is_last;
    holding_valid = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    items_sent++;
    update_matcher_state(f, sym, is_last);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        holding_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Sends name_buf as one name; an empty name goes out as a query.
  task automatic send_name();
    if (name_buf.size() == 0) begin
      send_item(gwm_pkg::FUNC_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      for (int i = 0; i < name_buf.size(); i++) begin
        send_item(gwm_pkg::FUNC_NAME, name_buf[i], i == name_buf.size() - 1);
      end
    end
  endtask

  task automatic send_bytes(input gwm_pkg::func_t f, input string s, input logic mark_end);
    for (int i = 0; i < s.len(); i++) begin
      send_item(f, s[i], mark_end && i == s.len() - 1);
    end
  endtask

  // Drops valid and waits until every result is back, plus the block's latency.
  task automatic settle_block();
    if (holding_valid) begin
      in_valid <= 1'b0;
      holding_valid = 1'b0;
    end
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fold(input logic v);
    settle_block();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fold_on = v;
  endtask

  function automatic logic [7:0] pick_glob_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return gwm_pkg::SYM_STAR;
    if (r < 35) return gwm_pkg::SYM_ANY;
    if (r < 55) return 8'($urandom_range(8'h61, 8'h63));
    if (r < 70) return 8'($urandom_range(8'h41, 8'h43));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_name_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h61, 8'h63));
    if (r < 60) return 8'($urandom_range(8'h41, 8'h43));
    if (r < 70) return gwm_pkg::SYM_STAR;
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds a name that the stored part of glob_buf accepts.
  task automatic build_matching_name();
    logic [7:0] b;
    name_buf.delete();
    for (int i = 0; i < glob_buf.size() && i < PATTERN_MAX; i++) begin
      b = glob_buf[i];
      if (b == gwm_pkg::SYM_STAR) begin
        repeat ($urandom_range(0, 3)) name_buf.insert(name_buf.size(), pick_name_byte());
      end else if (b == gwm_pkg::SYM_ANY) begin
        name_buf.insert(name_buf.size(), 8'($urandom_range(0, 255)));
      end else if (fold_on && $urandom_range(0, 1) == 1 &&
                   ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))) begin
        name_buf.insert(name_buf.size(), b ^ 8'h20);
      end else begin
        name_buf.insert(name_buf.size(), b);
      end
    end
  endtask

  task automatic load_glob(input int len);
    glob_buf.delete();
    send_item(gwm_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < len; i++) begin
      glob_buf.insert(glob_buf.size(), pick_glob_byte());
      send_item(gwm_pkg::FUNC_APPEND, glob_buf[i], 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed_basics();
    send_item(gwm_pkg::FUNC_QUERY, 8'hFF, 1'b1);
    send_item(gwm_pkg::FUNC_NAME, "a", 1'b1);
    send_item(gwm_pkg::FUNC_CLEAR, 8'hFF, 1'b1);
    send_item(gwm_pkg::FUNC_APPEND, "a", 1'b0);
    send_item(gwm_pkg::FUNC_APPEND, gwm_pkg::SYM_STAR, 1'b1);
    send_item(gwm_pkg::FUNC_APPEND, gwm_pkg::SYM_ANY, 1'b0);
    send_item(gwm_pkg::FUNC_APPEND, "Z", 1'b0);
    // A star in the name is an ordinary byte that the pattern '?' consumes.
    send_bytes(gwm_pkg::FUNC_NAME, "a*Z", 1'b1);
    send_bytes(gwm_pkg::FUNC_NAME, "axyz", 1'b1);
    // A query in the middle of a name ignores the bytes already streamed.
    send_item(gwm_pkg::FUNC_NAME, "a", 1'b0);
    send_item(gwm_pkg::FUNC_QUERY, "a", 1'b0);
    send_item(gwm_pkg::FUNC_APPEND, 8'h00, 1'b1);
    send_item(gwm_pkg::FUNC_APPEND, 8'hFF, 1'b0);
    send_bytes(gwm_pkg::FUNC_NAME, "aZZ", 1'b0);
    send_item(gwm_pkg::FUNC_NAME, 8'h00, 1'b0);
    send_item(gwm_pkg::FUNC_NAME, 8'hFF, 1'b1);
  endtask

  task automatic test_case_fold();
    write_fold(1'b1);
    send_item(gwm_pkg::FUNC_CLEAR, 8'h00, 1'b0);
    send_bytes(gwm_pkg::FUNC_APPEND, "@Z[", 1'b0);
    send_bytes(gwm_pkg::FUNC_NAME, "@z[", 1'b1);
    send_bytes(gwm_pkg::FUNC_NAME, "`Z{", 1'b1);
    write_fold(1'b0);
    send_bytes(gwm_pkg::FUNC_NAME, "@z[", 1'b1);
  endtask

  // Fills the pattern store and may push past it, so that the overflow flag can set.
  task automatic test_pattern_capacity();
    for (int round = 0; round < 3; round++) begin
      load_glob(PATTERN_MAX + $urandom_range(0, 3));
      repeat (2) begin
        build_matching_name();
        send_name();
      end
      send_item(gwm_pkg::FUNC_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    load_glob(PATTERN_MAX - 1);
    build_matching_name();
    send_name();
  endtask

  // The receiver holds off while names keep coming, so the block backs up.
  task automatic test_receiver_hold_off();
    settle_block();
    gaps_on = 1'b0;
    hold_seq <= hold_seq + 1;
    load_glob($urandom_range(1, 5));
    repeat (25) begin
      if ($urandom_range(0, 2) == 0) begin
        name_buf.delete();
      end else begin
        build_matching_name();
      end
      send_name();
    end
    gaps_on = 1'b1;
  endtask

  // Back-to-back names, then the sender pauses until every result has come and sends more names.
  task automatic test_pause_until_empty();
    gaps_on = 1'b0;
    load_glob($urandom_range(2, 8));
    repeat (6) begin
      build_matching_name();
      send_name();
    end
    settle_block();
    repeat (6) begin
      build_matching_name();
      send_name();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_globs();
    int r;
    int len;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        write_fold(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(gwm_pkg::func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 6);
      else if (r < 95) len = $urandom_range(7, 20);
      else len = $urandom_range(21, PATTERN_MAX + 3);
      load_glob(len);
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 9);
        build_matching_name();
        if (r >= 6 && r < 8 && name_buf.size() != 0) begin
          // Corrupt one byte of an otherwise matching name.
          name_buf[$urandom_range(0, name_buf.size() - 1)] = pick_name_byte();
        end else if (r >= 8) begin
          name_buf.delete();
          repeat ($urandom_range(0, 8)) name_buf.insert(name_buf.size(), pick_name_byte());
        end
        send_name();
      end
    end
  endtask

  // Receiver stall pattern: random segments of different density, plus a requested hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 150);
      end
      seg_left--;
      case (seg_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", verdicts_seen));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_matched !== want.matched) begin
          report_mismatch($sformatf("result %0d matched=%b, expected %b",
                                    verdicts_seen, out_matched, want.matched));
        end
        if (out_pattern_overflow !== want.overflow) begin
          report_mismatch($sformatf("result %0d pattern_overflow=%b, expected %b",
                                    verdicts_seen, out_pattern_overflow, want.overflow));
        end
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_fold(1'b0);
    test_directed_basics();
    test_case_fold();
    test_pattern_capacity();
    test_receiver_hold_off();
    test_pause_until_empty();
    test_random_globs();
    write_fold(1'b1);
    test_pause_until_empty();
    settle_block();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_cell.sv
hw/rtl/glob_wildcard_matcher.sv
verif/glob_wildcard_matcher_tb.sv
